@@ rtl/dcc_pkg.sv @@
`timescale 1ns / 1ps
package dcc_pkg;

   localparam int ROUNDS_DEF = 16;
   localparam logic [63:0] PAD_FULL = 64'h0808080808080808;

   typedef enum logic [2:0] {
      IDLE_ST = 3'b001,
      RUN_ST  = 3'b010,
      OUT_ST  = 3'b100
   } eng_state_type;

   // classified job between front and back
   typedef struct packed {
      logic [63:0] data;
      logic        first;
      logic        last;
      logic        extra;
      logic        decrypt;
   } job_type;

   localparam byte T_IP [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
   localparam byte T_FP [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
   localparam byte T_E [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
   localparam byte T_P [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
   localparam byte T_PC1 [56] = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
      19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
   localparam byte T_PC2 [48] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
   localparam logic [15:0] T_SHIFT2 = 16'b0111111011111100; // bit r: shift by 2
   localparam byte T_SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   function automatic logic [63:0] f_ip(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-T_IP[i]];
      return r;
   endfunction

   function automatic logic [63:0] f_fp(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-T_FP[i]];
      return r;
   endfunction

   function automatic logic [55:0] f_pc1(input logic [63:0] v);
      logic [55:0] r;
      for (int i = 0; i < 56; i++) r[55-i] = v[64-T_PC1[i]];
      return r;
   endfunction

   function automatic logic [47:0] f_pc2(input logic [55:0] v);
      logic [47:0] r;
      for (int i = 0; i < 48; i++) r[47-i] = v[56-T_PC2[i]];
      return r;
   endfunction

   // one Feistel round function
   function automatic logic [31:0] f_feistel(input logic [31:0] h, input logic [47:0] rk);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] r;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) x[47-i] = h[32-T_E[i]];
      x = x ^ rk;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = T_SBOX[i][{six[5], six[0], six[4:1]}][3:0];
      end
      for (int i = 0; i < 32; i++) r[31-i] = s[32-T_P[i]];
      return r;
   endfunction

endpackage

@@ rtl/dcc_ram.sv @@
`timescale 1ns / 1ps
module dcc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/dcc_front.sv @@
`timescale 1ns / 1ps
module dcc_front import dcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        decrypt,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_data,
   input  logic        req_first_block,
   input  logic        req_last_block,
   input  logic [3:0]  req_byte_count,
   output logic        job_valid,
   input  logic        job_take,
   output job_type     job
);
   job_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   job_type    nj;
   logic [3:0] n;
   logic [63:0] keep;
   logic        push, pop;

   // pad and classify the incoming beat
   always_comb begin
      n = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      keep = (n == 4'd0) ? 64'd0 : ~(64'hFFFFFFFFFFFFFFFF >> {n, 3'b000});
      nj.data = req_block_data;
      nj.first = req_first_block;
      nj.last = req_last_block;
      nj.decrypt = decrypt;
      nj.extra = 1'b0;
      if (!decrypt && req_last_block) begin
         if (n < 4'd8)
            nj.data = (req_block_data & keep) |
                      ({8{4'd0, 4'd8 - n}} & ~keep);
         else
            nj.extra = 1'b1;
      end
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = job_valid && job_take;
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rp_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   // advance the queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= nj;
   end
endmodule

@@ rtl/dcc_back.sv @@
`timescale 1ns / 1ps
module dcc_back import dcc_pkg::*; #(
   parameter int ROUNDS = ROUNDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] init_vector,
   input  logic [47:0] rk_data,
   output logic [$clog2(ROUNDS)-1:0] rk_addr,
   input  logic        job_valid,
   output logic        job_take,
   input  job_type     job,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_block_out,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_pad_error,
   output logic        rsp_last_out
);
   localparam int RW = $clog2(ROUNDS);

   eng_state_type st_ff;
   logic [RW-1:0] rnd_ff;
   logic [31:0]   l_ff, r_ff;
   logic [63:0]   chain_ff, cin_ff;
   logic          dec_ff, last_ff, extra_ff;
   logic [31:0]   r_new;
   logic [63:0]   des_out, plain;
   logic [63:0]   ob_ff;
   logic [3:0]    ovb_ff;
   logic          oerr_ff, olast_ff, ov_ff;
   logic          ok;
   logic [7:0]    p;
   logic [63:0]   chain_use, ip_in;
   logic          start, done, load;

   assign chain_use = job.first ? init_vector : chain_ff;
   assign ip_in = job.decrypt ? job.data : (job.data ^ chain_use);
   assign start = (st_ff == IDLE_ST) && job_valid;
   assign job_take = start;
   assign done = (st_ff == RUN_ST) && (rnd_ff == RW'(ROUNDS - 1));
   // hand the block to the result register once it is free or draining
   assign load = (st_ff == OUT_ST) && (!ov_ff || !rsp_stall);

   // key address is that of the next round, to cover the registered read
   always_comb begin
      if (st_ff == RUN_ST) rk_addr = dec_ff ? RW'(ROUNDS - 2) - rnd_ff : rnd_ff + RW'(1);
      else if (start) rk_addr = job.decrypt ? RW'(ROUNDS - 1) : RW'(0);
      else rk_addr = RW'(0);
   end

   assign r_new = f_feistel(r_ff, rk_data) ^ l_ff;
   // all rounds done: undo the last swap and apply the final permutation
   assign des_out = f_fp({r_ff, l_ff});
   assign plain = des_out ^ cin_ff;
   assign p = plain[7:0];

   // check PKCS#7 padding of the plaintext
   always_comb begin
      ok = (p >= 8'd1) && (p <= 8'd8);
      for (int i = 0; i < 8; i++)
         if (i < p && plain[8*i +: 8] != p) ok = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IDLE_ST;
         chain_ff <= 64'd0;
         ov_ff <= 1'b0;
         rnd_ff <= '0;
      end else begin
         ov_ff <= load || (ov_ff && rsp_stall);
         case (st_ff)
            IDLE_ST: if (start) begin
               st_ff <= RUN_ST;
               rnd_ff <= '0;
               {l_ff, r_ff} <= f_ip(ip_in);
               cin_ff <= chain_use;
               dec_ff <= job.decrypt;
               last_ff <= job.last;
               extra_ff <= job.extra;
               if (job.decrypt) chain_ff <= job.data;
            end
            RUN_ST: begin
               rnd_ff <= rnd_ff + RW'(1);
               l_ff <= r_ff;
               r_ff <= r_new;
               if (done) st_ff <= OUT_ST;
            end
            OUT_ST: if (load) begin
               // load the result register and drop back or chain the pad block
               ob_ff <= dec_ff ? plain : des_out;
               if (!dec_ff) chain_ff <= des_out;
               ovb_ff <= (dec_ff && last_ff) ? (ok ? 4'd8 - p[3:0] : 4'd0) : 4'd8;
               oerr_ff <= dec_ff && last_ff && !ok;
               olast_ff <= last_ff && !extra_ff;
               if (extra_ff) begin
                  st_ff <= RUN_ST;
                  rnd_ff <= '0;
                  {l_ff, r_ff} <= f_ip(PAD_FULL ^ des_out);
                  extra_ff <= 1'b0;
               end else begin
                  st_ff <= IDLE_ST;
               end
            end
            default: st_ff <= IDLE_ST;
         endcase
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_block_out = ob_ff;
   assign rsp_valid_bytes = ovb_ff;
   assign rsp_pad_error = oerr_ff;
   assign rsp_last_out = olast_ff;
endmodule

@@ rtl/dcc_keysched.sv @@
`timescale 1ns / 1ps
module dcc_keysched import dcc_pkg::*; #(
   parameter int ROUNDS = ROUNDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        key_load,
   input  logic [63:0] key,
   output logic        wr_en,
   output logic [$clog2(ROUNDS)-1:0] wr_addr,
   output logic [47:0] wr_data
);
   localparam int RW = $clog2(ROUNDS);
   logic [27:0] c_ff, d_ff, c_n, d_n;
   logic [RW-1:0] idx_ff;
   logic          busy_ff;
   logic [55:0]   k;
   logic          two;

   assign k = f_pc1(key);
   assign two = T_SHIFT2[idx_ff];
   assign c_n = two ? {c_ff[25:0], c_ff[27:26]} : {c_ff[26:0], c_ff[27]};
   assign d_n = two ? {d_ff[25:0], d_ff[27:26]} : {d_ff[26:0], d_ff[27]};
   assign wr_en = busy_ff;
   assign wr_addr = idx_ff;
   assign wr_data = f_pc2({c_n, d_n});

   // sweep the round keys one per cycle after reset or a key write
   always_ff @(posedge clock) begin
      if (reset || key_load) begin
         busy_ff <= 1'b1;
         idx_ff <= '0;
         c_ff <= reset ? 28'd0 : k[55:28];
         d_ff <= reset ? 28'd0 : k[27:0];
      end else if (busy_ff) begin
         c_ff <= c_n;
         d_ff <= d_n;
         idx_ff <= idx_ff + RW'(1);
         if (idx_ff == RW'(ROUNDS - 1)) busy_ff <= 1'b0;
      end
   end
endmodule

@@ rtl/des_cbc_cipher_core.sv @@
`timescale 1ns / 1ps
// channel  | valid      | stall      | payload
// req      | req_valid  | req_stall  | block_data first_block last_block byte_count
// rsp      | rsp_valid  | rsp_stall  | block_out valid_bytes pad_error last_out
// csr      | csr_wr_en  | -          | csr_index csr_data
// In the round engine an item passes a load step, one Feistel round a cycle,
// and a hand-off of the block to the result register; a full last encrypt
// block then runs the rounds again for its pad block.
// A two-entry queue lets the front take beats while the engine works.
// After reset or a key write the round keys are rebuilt.
// Reset is synchronous, active high; a stalled result holds in its register
// and the engine waits with its next block until that register drains.
module des_cbc_cipher_core import dcc_pkg::*; #(
   parameter int ROUNDS = ROUNDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_data,
   input  logic        req_first_block,
   input  logic        req_last_block,
   input  logic [3:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_block_out,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_pad_error,
   output logic        rsp_last_out
);
   localparam int RW = $clog2(ROUNDS);
   localparam logic [1:0] REG_KEY = 2'd0, REG_IV = 2'd1, REG_MODE = 2'd2;

   logic [63:0] iv_ff;
   logic        mode_ff;
   logic        wr_en, job_valid, job_take;
   logic [RW-1:0] wr_addr, rk_addr;
   logic [47:0] wr_data, rk_data;
   job_type     job;

   // hold the configuration registers; the key goes straight to the scheduler
   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 64'd0;
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IV: iv_ff <= csr_data;
            REG_MODE: mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   dcc_keysched #(.ROUNDS(ROUNDS)) u_ks (
      .clock, .reset, .key_load(csr_wr_en && csr_index == REG_KEY), .key(csr_data),
      .wr_en, .wr_addr, .wr_data);

   dcc_ram #(.WIDTH(48), .DEPTH(ROUNDS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr(rk_addr), .rd_data(rk_data));

   dcc_front u_front (
      .clock, .reset, .decrypt(mode_ff), .req_valid, .req_stall, .req_block_data,
      .req_first_block, .req_last_block, .req_byte_count, .job_valid, .job_take, .job);

   dcc_back #(.ROUNDS(ROUNDS)) u_back (
      .clock, .reset, .init_vector(iv_ff), .rk_data, .rk_addr, .job_valid, .job_take,
      .job, .rsp_valid, .rsp_stall, .rsp_block_out, .rsp_valid_bytes, .rsp_pad_error,
      .rsp_last_out);

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pad_error |-> rsp_last_out)
      else $error("pad error off last");
   a_vb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pad_error |-> rsp_valid_bytes <= 4'd8)
      else $error("valid bytes range");
   a_err_vb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pad_error |-> rsp_valid_bytes == 4'd0)
      else $error("error count");
endmodule

@@ tb/des_cbc_cipher_core_tb.sv @@
`timescale 1ns / 1ps
module des_cbc_cipher_core_tb;
   import dcc_pkg::*;

   localparam logic [1:0] REG_KEY   = 2'd0;
   localparam logic [1:0] REG_IV    = 2'd1;
   localparam logic [1:0] REG_MODE  = 2'd2;
   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 2 * (ROUNDS_DEF + 2) + 8;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef struct {
      logic [63:0] text;
      logic [3:0]  kept;
      logic        bad_pad;
      logic        tail;
   } cbc_result_type;

   // DES-CBC with PKCS#7 padding, tracked beat by beat
   class cbc_scoreboard;
      logic [47:0] subkey [16];
      logic [63:0] iv_reg;
      logic [63:0] chain;
      logic        decrypting;
      cbc_result_type due [$];
      int          errors;

      function new();
         iv_reg = '0;
         chain = '0;
         decrypting = 1'b0;
         errors = 0;
         load_key('0);
      endfunction

      function void load_key(logic [63:0] k);
         logic [55:0] cd;
         logic [27:0] c;
         logic [27:0] d;
         int sh;
         for (int i = 0; i < 56; i++) cd[55-i] = k[64-T_PC1[i]];
         c = cd[55:28];
         d = cd[27:0];
         for (int r = 0; r < 16; r++) begin
            sh = T_SHIFT2[r] ? 2 : 1;
            c = (c << sh) | (c >> (28 - sh));
            d = (d << sh) | (d >> (28 - sh));
            cd = {c, d};
            for (int i = 0; i < 48; i++) subkey[r][47-i] = cd[56-T_PC2[i]];
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] val);
         case (idx)
            REG_KEY: load_key(val);
            REG_IV: iv_reg = val;
            REG_MODE: decrypting = val[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] mix(logic [31:0] h, logic [47:0] k);
         logic [47:0] x;
         logic [31:0] s;
         logic [31:0] p;
         logic [5:0]  six;
         for (int i = 0; i < 48; i++) x[47-i] = h[32-T_E[i]];
         x = x ^ k;
         for (int i = 0; i < 8; i++) begin
            six = x[47-6*i -: 6];
            s[31-4*i -: 4] = T_SBOX[i][{six[5], six[0]} * 16 + six[4:1]][3:0];
         end
         for (int i = 0; i < 32; i++) p[31-i] = s[32-T_P[i]];
         return p;
      endfunction

      function logic [63:0] des_crypt(logic [63:0] blk, bit inverse);
         logic [63:0] v;
         logic [63:0] o;
         logic [31:0] l;
         logic [31:0] r;
         logic [31:0] t;
         for (int i = 0; i < 64; i++) v[63-i] = blk[64-T_IP[i]];
         l = v[63:32];
         r = v[31:0];
         for (int i = 0; i < 16; i++) begin
            t = r;
            r = mix(r, subkey[inverse ? 15 - i : i]) ^ l;
            l = t;
         end
         v = {r, l};
         for (int i = 0; i < 64; i++) o[63-i] = v[64-T_FP[i]];
         return o;
      endfunction

      function void push(logic [63:0] t, logic [3:0] k, logic e, logic z);
         cbc_result_type x;
         x.text = t;
         x.kept = k;
         x.bad_pad = e;
         x.tail = z;
         due.push_back(x);
      endfunction

      // work out the results of one accepted block
      function void note_block(logic [63:0] data, logic first, logic last,
                               logic [3:0] count);
         logic [63:0] plain;
         logic [63:0] keep;
         logic [7:0]  p;
         int n;
         bit ok;
         n = (count > 8) ? 8 : count;
         if (first) chain = iv_reg;
         if (decrypting) begin
            plain = des_crypt(data, 1) ^ chain;
            chain = data;
            if (!last) begin
               push(plain, 4'd8, 1'b0, 1'b0);
               return;
            end
            p = plain[7:0];
            ok = (p >= 1 && p <= 8);
            for (int i = 0; ok && i < p; i++)
               if (plain[8*i +: 8] != p) ok = 0;
            push(plain, ok ? 4'(8 - p) : 4'd0, !ok, 1'b1);
            return;
         end
         if (last && n < 8) begin
            keep = (n == 0) ? '0 : ~64'd0 << (64 - 8 * n);
            data = (data & keep) | ({8{8'(8 - n)}} & ~keep);
         end
         chain = des_crypt(data ^ chain, 0);
         if (!last || n < 8) begin
            push(chain, 4'd8, 1'b0, last);
            return;
         end
         push(chain, 4'd8, 1'b0, 1'b0);
         chain = des_crypt(PAD_FULL ^ chain, 0);
         push(chain, 4'd8, 1'b0, 1'b1);
      endfunction

      function void check_result(logic [63:0] t, logic [3:0] k, logic e, logic z);
         cbc_result_type x;
         if (due.size() == 0) begin
            $error("unexpected result beat block_out=%h", t);
            errors++;
            return;
         end
         x = due.pop_front();
         if (t !== x.text) begin
            $error("block_out expected %h actual %h", x.text, t);
            errors++;
         end
         if (k !== x.kept) begin
            $error("valid_bytes expected %0d actual %0d", x.kept, k);
            errors++;
         end
         if (e !== x.bad_pad) begin
            $error("pad_error expected %0b actual %0b", x.bad_pad, e);
            errors++;
         end
         if (z !== x.tail) begin
            $error("last_out expected %0b actual %0b", x.tail, z);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [63:0] req_block_data = '0;
   logic        req_first_block = 0;
   logic        req_last_block = 0;
   logic [3:0]  req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_block_out;
   logic [3:0]  rsp_valid_bytes;
   logic        rsp_pad_error;
   logic        rsp_last_out;

   cbc_scoreboard sb = new();
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int items = 0;
   logic [63:0] cur_iv = '0;

   des_cbc_cipher_core uut (.*);

   always #10 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // check result beats and stall on a pattern that is picked anew at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_block_out, rsp_valid_bytes, rsp_pad_error, rsp_last_out);
      if (cycles % 50 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic send_block(logic [63:0] d, logic f, logic l, logic [3:0] n);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_block_data <= d;
      req_first_block <= f;
      req_last_block <= l;
      req_byte_count <= n;
      do @(posedge clock); while (req_stall);
      sb.note_block(d, f, l, n);
      burst_left--;
      items++;
   endtask

   // drain all results, then let the engine settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      if (idx == REG_IV) cur_iv = val;
      csr_wr_en <= 1'b0;
      repeat (ROUNDS_DEF + 4) @(posedge clock);
   endtask

   // plaintext message of nblk blocks, random counts
   task automatic enc_message(int nblk);
      for (int i = 0; i < nblk; i++)
         send_block({$urandom, $urandom}, i == 0, i == nblk - 1,
                    4'($urandom_range(0, 15)));
   endtask

   // ciphertext of a message whose last block carries pad value p;
   // corrupt spoils byte 1, which is a pad byte when p is at least 2
   task automatic dec_message(int nblk, int p, bit corrupt);
      logic [63:0] prev;
      logic [63:0] pt;
      prev = cur_iv;
      for (int i = 0; i < nblk; i++) begin
         pt = {$urandom, $urandom};
         if (i == nblk - 1) begin
            for (int b = 0; b < 8; b++) if (b < p) pt[8*b +: 8] = 8'(p);
            pt[7:0] = 8'(p);
            if (corrupt) pt[15:8] = ~8'(p);
         end
         prev = sb.des_crypt(pt ^ prev, 0);
         send_block(prev, i == 0, i == nblk - 1, 4'($urandom_range(0, 15)));
      end
   endtask

   initial begin
      logic [63:0] keys [4];
      int goal;
      keys = '{64'd0, ~64'd0, 64'h0123456789ABCDEF, 64'h133457799BBCDFF1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // block with no first flag runs from the reset chain and zero key
      send_block(64'h0123456789ABCDEF, 1'b0, 1'b0, 4'd8);
      send_block('0, 1'b0, 1'b1, 4'd8);
      wait_idle();
      write_reg(REG_SPARE, ~64'd0);
      write_reg(REG_KEY, 64'h133457799BBCDFF1);
      write_reg(REG_IV, ~64'd0);
      write_reg(REG_MODE, 64'd0);

      // each pad length, an oversized count, and a count on a middle block
      for (int n = 0; n <= 8; n++) send_block(~64'd0, 1'b1, 1'b1, 4'(n));
      send_block('0, 1'b1, 1'b1, 4'd15);
      send_block({$urandom, $urandom}, 1'b1, 1'b0, 4'd2);
      send_block({$urandom, $urandom}, 1'b0, 1'b1, 4'd8);
      wait_idle();

      // every pad value, in range or not, plus messages with a spoiled pad byte
      write_reg(REG_MODE, 64'd1);
      for (int p = 0; p <= 9; p++) dec_message(1, p, 0);
      dec_message(2, 4, 1);
      dec_message(1, 8, 1);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_KEY, (ph < 4) ? keys[ph] : {$urandom, $urandom});
         write_reg(REG_IV, (ph == 0) ? 64'd0 : (ph == 1) ? ~64'd0 : {$urandom, $urandom});
         write_reg(REG_MODE, 64'(ph % 2));
         goal = items + 70;
         while (items < goal) begin
            if ($urandom_range(0, 9) == 0)
               send_block({$urandom, $urandom}, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            else if (ph % 2 == 0)
               enc_message($urandom_range(1, 5));
            else
               dec_message($urandom_range(1, 5), $urandom_range(1, 9) % 9 + 0,
                           $urandom_range(0, 7) == 0);
         end
         wait_idle();
      end

      if (sb.errors == 0 && sb.due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/dcc_pkg.sv
rtl/dcc_ram.sv
rtl/dcc_front.sv
rtl/dcc_back.sv
rtl/dcc_keysched.sv
rtl/des_cbc_cipher_core.sv
tb/des_cbc_cipher_core_tb.sv
